FILE: hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, operation codes and controller states of the first-fit
// block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ARENA_BYTES_DEF = 1024;
  localparam int ALIGN_BYTES_DEF = 16;
  localparam int HDR_MIN_BYTES   = 16;
  localparam int OFS_W           = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_FWR,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/first_fit_block_allocator.sv
// Allocate walks the header chain, one header per cycle through the header RAM
// read port, with an extra header write when the block is split. Free is one
// read-modify-write of the header RAM. One request is taken at a time.
// Reset: synchronous, active low; the first header reads as one free block
// of the whole arena until it is first written, no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with block splitting over a granule-indexed header RAM.
// ALIGN_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF,
  parameter int ALIGN_BYTES = ffba_pkg::ALIGN_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [ffba_pkg::OFS_W-1:0] in_req_size,
  input  logic [ffba_pkg::OFS_W-1:0] in_free_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ffba_pkg::OFS_W-1:0] out_payload_offset,
  output logic                       out_ok
);

  localparam int OW       = ffba_pkg::OFS_W;
  localparam int GRANULES = ARENA_BYTES / ALIGN_BYTES;
  localparam int HDR_G    = (ffba_pkg::HDR_MIN_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int HDR_B    = HDR_G * ALIGN_BYTES;
  localparam int LG       = $clog2(ALIGN_BYTES);
  localparam int GW       = $clog2(GRANULES);
  localparam int SW       = $clog2(ARENA_BYTES);
  localparam int CW       = ((SW > OW) ? SW : OW) + 2;
  localparam int EW       = GW + SW + 2;

  localparam logic [CW-1:0] HDR_C    = CW'(HDR_B);
  localparam logic [CW-1:0] HDRG_C   = CW'(HDR_G);
  localparam logic [CW-1:0] ALIGN_C  = CW'(ALIGN_BYTES);
  localparam logic [CW-1:0] AMASK_C  = CW'(ALIGN_BYTES - 1);
  localparam logic [CW-1:0] GRAN_C   = CW'(GRANULES);
  localparam logic [SW-1:0] INIT_SZ  = SW'(ARENA_BYTES - HDR_B);

  ffba_pkg::state_t state_r, state_nxt;

  logic [GW-1:0] g_r, g_nxt;
  logic [GW-1:0] ng_r, ng_nxt;
  logic [CW-1:0] want_r, want_nxt;
  logic [OW-1:0] req_r, req_nxt;
  logic [OW-1:0] res_off_r, res_off_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OW-1:0] out_off_r, out_off_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic          h0_wr_r, h0_wr_nxt;
  logic          rd0_r, rd0_nxt;

  logic          mem_we, mem_re;
  logic [GW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata, hdr;

  logic [GW-1:0] b_next;
  logic          b_has_next;
  logic [SW-1:0] b_size;
  logic          b_in_use;

  logic [CW-1:0] b_size_c, ng_full, g_off, f_off, f_hb;
  logic          hit, split, free_ok;

  ffba_ram #(
    .WIDTH(EW),
    .DEPTH(GRANULES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // first header holds its reset value until written
  assign hdr = (rd0_r && !h0_wr_r) ? {GW'(0), 1'b0, INIT_SZ, 1'b0} : mem_rdata;
  assign {b_next, b_has_next, b_size, b_in_use} = hdr;

  assign b_size_c = CW'(b_size);
  assign ng_full  = CW'(g_r) + HDRG_C + (want_r >> LG);
  assign g_off    = (CW'(g_r) << LG) + HDR_C;
  assign hit      = !b_in_use && (b_size_c >= CW'(req_r));
  assign split    = ((want_r + HDR_C + ALIGN_C) <= b_size_c) && (ng_full < GRAN_C);

  assign f_off    = CW'(in_free_offset);
  assign f_hb     = f_off - HDR_C;
  assign free_ok  = (f_off >= HDR_C) && ((f_off & AMASK_C) == '0) && ((f_hb >> LG) < GRAN_C);

  always_comb begin
    state_nxt     = state_r;
    g_nxt         = g_r;
    ng_nxt        = ng_r;
    want_nxt      = want_r;
    req_nxt       = req_r;
    res_off_nxt   = res_off_r;
    res_ok_nxt    = res_ok_r;
    out_off_nxt   = out_off_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = g_r;
    mem_wdata     = hdr;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      ffba_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_req_size;
          want_nxt    = (CW'(in_req_size) + AMASK_C) & ~AMASK_C;
          res_off_nxt = '0;
          res_ok_nxt  = 1'b0;
          if (in_op == ffba_pkg::OP_ALLOC) begin
            g_nxt     = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = ffba_pkg::ST_WALK;
          end else if (free_ok) begin
            g_nxt     = GW'(f_hb >> LG);
            mem_re    = 1'b1;
            mem_raddr = GW'(f_hb >> LG);
            state_nxt = ffba_pkg::ST_FWR;
          end else begin
            state_nxt = ffba_pkg::ST_DONE;
          end
        end
      end
      ffba_pkg::ST_WALK: begin
        if (hit) begin
          res_off_nxt = OW'(g_off);
          res_ok_nxt  = 1'b1;
          if (split) begin
            mem_we    = 1'b1;
            mem_waddr = GW'(ng_full);
            mem_wdata = {b_next, b_has_next, SW'(b_size_c - want_r - HDR_C), 1'b0};
            ng_nxt    = GW'(ng_full);
            state_nxt = ffba_pkg::ST_SPLIT;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = g_r;
            mem_wdata = {b_next, b_has_next, b_size, 1'b1};
            state_nxt = ffba_pkg::ST_DONE;
          end
        end else if (!b_has_next) begin
          state_nxt = ffba_pkg::ST_DONE;
        end else begin
          g_nxt     = b_next;
          mem_re    = 1'b1;
          mem_raddr = b_next;
        end
      end
      ffba_pkg::ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = g_r;
        mem_wdata = {ng_r, 1'b1, SW'(want_r), 1'b1};
        state_nxt = ffba_pkg::ST_DONE;
      end
      ffba_pkg::ST_FWR: begin
        mem_we     = 1'b1;
        mem_waddr  = g_r;
        mem_wdata  = {b_next, b_has_next, b_size, 1'b0};
        res_ok_nxt = 1'b1;
        state_nxt  = ffba_pkg::ST_DONE;
      end
      ffba_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_ok_nxt    = res_ok_r;
          state_nxt     = ffba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffba_pkg::ST_IDLE;
    endcase

    h0_wr_nxt = h0_wr_r || (mem_we && (mem_waddr == '0));
    rd0_nxt   = mem_re ? (mem_raddr == '0) : rd0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      h0_wr_r     <= 1'b0;
      rd0_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      h0_wr_r     <= h0_wr_nxt;
      rd0_r       <= rd0_nxt;
    end
    g_r       <= g_nxt;
    ng_r      <= ng_nxt;
    want_r    <= want_nxt;
    req_r     <= req_nxt;
    res_off_r <= res_off_nxt;
    res_ok_r  <= res_ok_nxt;
    out_off_r <= out_off_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign in_stall           = (state_r != ffba_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_payload_offset = out_off_r;
  assign out_ok             = out_ok_r;

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ffba_pkg::ST_DONE))
    else $error("result issued outside completion state");

  a_split_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::ST_SPLIT) |-> $past(state_r == ffba_pkg::ST_WALK))
    else $error("split write not preceded by header walk");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_off_r == '0))
    else $error("failed request carries non-zero offset");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::ST_IDLE || state_r == ffba_pkg::ST_DONE) |-> !mem_we)
    else $error("header write outside a request");
`endif

endmodule

FILE: hw/rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: verif/tb_first_fit_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A short table of
// directed requests covers reset, padding, oversized and rejected frees and
// the exact-fit split; a long random mix of allocate and free requests then
// fragments the arena. Every result is checked against an in-bench model of
// the header chain or a listed result, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

  localparam int OW         = ffba_pkg::OFS_W;
  localparam int ALIGN      = ffba_pkg::ALIGN_BYTES_DEF;
  localparam int HDR        = ((ffba_pkg::HDR_MIN_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
  localparam int GRAN       = ffba_pkg::ARENA_BYTES_DEF / ALIGN;
  localparam int NUM_DIR    = 23;
  localparam int NUM_RANDOM = 2000;
  localparam int LIMIT      = 1000000;

  typedef struct packed {
    logic          op;
    logic [OW-1:0] req_size;
    logic [OW-1:0] free_offset;
  } alloc_req_t;

  typedef struct packed {
    logic [OW-1:0] payload_offset;
    logic          ok;
  } alloc_res_t;

  typedef struct packed {
    logic          op;
    logic [OW-1:0] req_size;
    logic [OW-1:0] free_offset;
    logic          known;
    logic [OW-1:0] known_offset;
    logic          known_ok;
  } dir_row_t;

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  logic          in_op          = ffba_pkg::OP_ALLOC;
  logic [OW-1:0] in_req_size    = '0;
  logic [OW-1:0] in_free_offset = '0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  logic [OW-1:0] out_payload_offset;
  logic          out_ok;

  // Header chain as the block should hold it
  int hdr_next     [GRAN];
  bit hdr_has_next [GRAN];
  int hdr_size     [GRAN];
  bit hdr_used     [GRAN];
  bit hdr_written  [GRAN];

  alloc_res_t pending_results[$];

  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  int cycles     = 0;
  int failures   = 0;
  int n_alloc = 0, n_alloc_ok = 0, n_split = 0, n_free = 0, n_free_ok = 0;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{ffba_pkg::OP_ALLOC, 10'd1023, 10'd0,    1'b1, 10'd0,  1'b0},  // too large at reset
    '{ffba_pkg::OP_ALLOC, 10'd0,    10'd0,    1'b1, 10'd16, 1'b1},  // zero pads to zero
    '{ffba_pkg::OP_FREE,  10'd0,    10'd0,    1'b1, 10'd0,  1'b0},  // below first payload
    '{ffba_pkg::OP_FREE,  10'd0,    10'd15,   1'b1, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd17,   1'b1, 10'd0,  1'b0},  // misaligned
    '{ffba_pkg::OP_FREE,  10'd0,    10'd1023, 1'b1, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd1,    10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd16,   10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd16,   1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd16,   1'b0, 10'd0,  1'b0},  // double free
    '{ffba_pkg::OP_ALLOC, 10'd0,    10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd1000, 10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd17,   10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd64,   1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd16,   10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd880,  10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd0,    10'd0,    1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd144,  1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd848,  10'd0,    1'b0, 10'd0,  1'b0},  // split with exact room
    '{ffba_pkg::OP_ALLOC, 10'd16,   10'd0,    1'b0, 10'd0,  1'b0},  // top of arena
    '{ffba_pkg::OP_FREE,  10'd0,    10'd1008, 1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_FREE,  10'd0,    10'd144,  1'b0, 10'd0,  1'b0},
    '{ffba_pkg::OP_ALLOC, 10'd1008, 10'd0,    1'b0, 10'd0,  1'b0}
  };

  first_fit_block_allocator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_req_size        (in_req_size),
    .in_free_offset     (in_free_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_offset (out_payload_offset),
    .out_ok             (out_ok)
  );

  always #5 clk = ~clk;

  function automatic alloc_res_t allocate_or_release(input alloc_req_t r);
    alloc_res_t res;
    int want, g, ng, steps, off, req;
    res = '0;
    if (r.op == ffba_pkg::OP_ALLOC) begin
      n_alloc++;
      req  = r.req_size;
      want = ((req + ALIGN - 1) / ALIGN) * ALIGN;
      g    = 0;
      for (steps = 0; steps < GRAN && g < GRAN; steps++) begin
        if (!hdr_used[g] && hdr_size[g] >= req) begin
          if (want + HDR + ALIGN <= hdr_size[g]) begin
            ng = (g * ALIGN + HDR + want) / ALIGN;
            if (ng < GRAN) begin
              hdr_next[ng]     = hdr_next[g];
              hdr_has_next[ng] = hdr_has_next[g];
              hdr_size[ng]     = hdr_size[g] - want - HDR;
              hdr_used[ng]     = 1'b0;
              hdr_written[ng]  = 1'b1;
              hdr_next[g]      = ng;
              hdr_has_next[g]  = 1'b1;
              hdr_size[g]      = want;
              n_split++;
            end
          end
          hdr_used[g]        = 1'b1;
          res.payload_offset = OW'(g * ALIGN + HDR);
          res.ok             = 1'b1;
          n_alloc_ok++;
          return res;
        end
        if (!hdr_has_next[g]) break;
        g = hdr_next[g];
      end
    end else begin
      n_free++;
      off = r.free_offset;
      if (off >= HDR && (off - HDR) % ALIGN == 0 && (off - HDR) / ALIGN < GRAN) begin
        hdr_used[(off - HDR) / ALIGN] = 1'b0;
        res.ok = 1'b1;
        n_free_ok++;
      end
    end
    return res;
  endfunction

  // Mostly live blocks, some chain headers of either state, the rest noise; an aligned
  // offset onto a granule that was never a header is steered to granule 0.
  function automatic logic [OW-1:0] pick_free_offset();
    int live[$];
    int hdrs[$];
    int g, steps, sel;
    logic [OW-1:0] o;
    g = 0;
    for (steps = 0; steps < GRAN; steps++) begin
      hdrs.push_back(g);
      if (hdr_used[g]) live.push_back(g);
      if (!hdr_has_next[g]) break;
      g = hdr_next[g];
    end
    sel = $urandom_range(0, 99);
    if (sel < 60 && live.size() > 0) begin
      o = OW'(live[$urandom_range(0, live.size() - 1)] * ALIGN + HDR);
    end else if (sel < 75) begin
      o = OW'(hdrs[$urandom_range(0, hdrs.size() - 1)] * ALIGN + HDR);
    end else begin
      o = OW'($urandom);
      if (o >= HDR && (o - HDR) % ALIGN == 0 && !hdr_written[(o - HDR) / ALIGN]) o = OW'(HDR);
    end
    return o;
  endfunction

  function automatic logic [OW-1:0] pick_req_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return OW'($urandom_range(0, 48));
    if (sel < 9) return OW'($urandom_range(0, 255));
    return OW'($urandom_range(0, 1023));
  endfunction

  task automatic send_request(input alloc_req_t r, input bit known, input alloc_res_t known_res);
    alloc_res_t p;
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_op          = r.op;
    in_req_size    = r.req_size;
    in_free_offset = r.free_offset;
    do @(posedge clk); while (in_stall);
    p = allocate_or_release(r);
    if (known) p = known_res;
    pending_results.push_back(p);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    alloc_res_t want_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: offset %0d ok %0d", out_payload_offset, out_ok);
      end else begin
        want_res = pending_results.pop_front();
        if (out_payload_offset !== want_res.payload_offset || out_ok !== want_res.ok) begin
          failures++;
          if (failures <= 10)
            $display("Mismatch: expected offset %0d ok %0d, got offset %0d ok %0d",
                     want_res.payload_offset, want_res.ok, out_payload_offset, out_ok);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    alloc_req_t r;
    alloc_res_t lit;
    int i;
    for (i = 0; i < GRAN; i++) begin
      hdr_next[i]     = 0;
      hdr_has_next[i] = 1'b0;
      hdr_size[i]     = 0;
      hdr_used[i]     = 1'b0;
      hdr_written[i]  = 1'b0;
    end
    hdr_size[0]    = ffba_pkg::ARENA_BYTES_DEF - HDR;
    hdr_written[0] = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    idle_on  = 1'b1;
    stall_on = 1'b1;

    for (i = 0; i < NUM_DIR; i++) begin
      r.op               = dir_tab[i].op;
      r.req_size         = dir_tab[i].req_size;
      r.free_offset      = dir_tab[i].free_offset;
      lit.payload_offset = dir_tab[i].known_offset;
      lit.ok             = dir_tab[i].known_ok;
      send_request(r, dir_tab[i].known, lit);
    end

    for (i = 0; i < NUM_RANDOM; i++) begin
      idle_on  = !(i >= 700 && i < 900) && (i < NUM_RANDOM - 200);
      stall_on = idle_on;
      if (i == 1000) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 55) begin
        r.op          = ffba_pkg::OP_ALLOC;
        r.req_size    = pick_req_size();
        r.free_offset = OW'($urandom);
      end else begin
        r.op          = ffba_pkg::OP_FREE;
        r.req_size    = OW'($urandom);
        r.free_offset = pick_free_offset();
      end
      send_request(r, 1'b0, '0);
    end
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Run covered %0d allocates (%0d granted, %0d with a split)", n_alloc, n_alloc_ok,
             n_split);
    $display("and %0d frees (%0d taken), %0d failures", n_free, n_free_ok, failures);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
